FILE: hw/rtl/fmcw_chirp_generator_defines.svh
// ----------------------------------------------------------------------------
// fmcw chirp generator assertion macros
// shared assertion forms for the chirp generator checker
// ----------------------------------------------------------------------------
`ifndef FMCW_CHIRP_GENERATOR_DEFINES_SVH
`define FMCW_CHIRP_GENERATOR_DEFINES_SVH

// same-cycle implication, sampled on the rising clock edge outside reset
`define FCG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on the rising clock edge outside reset
`define FCG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/fcg_pkg.sv
// ----------------------------------------------------------------------------
// fcg_pkg
// shared types, constants and table builder of the fmcw chirp generator
// ----------------------------------------------------------------------------
`default_nettype none

package fcg_pkg;

  localparam int FCG_PHASE_BITS    = 32;
  localparam int FCG_LUT_ADDR_BITS = 10;
  localparam int FCG_SAMPLE_BITS   = 16;
  localparam int FCG_LEN_BITS      = 16;

  localparam int OUT_BITS      = 16;
  localparam int FREQ_BITS     = 32;
  localparam int CFG_LEN_BITS  = 16;
  localparam int APB_ADDR_BITS = 5;
  localparam int APB_DATA_BITS = 32;
  localparam int QUEUE_DEPTH   = 4;

  localparam logic [15:0] AMP_RESET = 16'h8000;

  // pi in q30 and the q30 rounding half
  localparam logic [63:0] PI_Q30   = 64'd3373259426;
  localparam logic [63:0] Q30_HALF = 64'd1 << 29;

  typedef enum logic [2:0] {
    REG_CW_LEN      = 3'd0,
    REG_UP_LEN      = 3'd1,
    REG_DOWN_LEN    = 3'd2,
    REG_BASE_FREQ   = 3'd3,
    REG_SWEEP_WIDTH = 3'd4,
    REG_UP_STEP     = 3'd5,
    REG_DOWN_STEP   = 3'd6,
    REG_AMPLITUDE   = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    SEG_CW   = 2'd0,
    SEG_UP   = 2'd1,
    SEG_DOWN = 2'd2
  } seg_t;

  // per-sample control handed from the sequencer to the datapath
  typedef struct packed {
    logic start;
    seg_t seg;
  } fcg_ctl_t;

  typedef struct packed {
    logic        [15:0] cw_len;
    logic        [15:0] up_len;
    logic        [15:0] down_len;
    logic signed [31:0] base_freq;
    logic signed [31:0] sweep_width;
    logic signed [31:0] up_step;
    logic signed [31:0] down_step;
    logic        [15:0] amplitude;
  } fcg_cfg_t;

  // rounded division of a taylor term by (2n)(2n+1)
  function automatic logic [63:0] fcg_taylor_div(input logic [63:0] term, input int n);
    logic [63:0] q;
    unique case (n)
      1:       q = (term + 64'd3)   / 64'd6;
      2:       q = (term + 64'd10)  / 64'd20;
      3:       q = (term + 64'd21)  / 64'd42;
      4:       q = (term + 64'd36)  / 64'd72;
      5:       q = (term + 64'd55)  / 64'd110;
      6:       q = (term + 64'd78)  / 64'd156;
      7:       q = (term + 64'd105) / 64'd210;
      8:       q = (term + 64'd136) / 64'd272;
      9:       q = (term + 64'd171) / 64'd342;
      10:      q = (term + 64'd210) / 64'd420;
      default: q = term;
    endcase
    return q;
  endfunction

  // quarter-wave sine entry k, q30 taylor series with eleven terms
  function automatic logic [63:0] fcg_sine_entry(input int k, input int addr_bits,
                                                 input int sample_bits);
    logic        [63:0] x;
    logic        [63:0] x2;
    logic        [63:0] term;
    logic        [63:0] sine_fs;
    logic        [63:0] val;
    logic signed [63:0] sum;
    sine_fs = (64'd1 << (sample_bits - 1)) - 64'd1;
    x       = (64'(k) * PI_Q30 + (64'd1 << addr_bits)) >> (addr_bits + 1);
    x2      = (x * x + Q30_HALF) >> 30;
    term    = x;
    sum     = signed'(x);
    for (int n = 1; n <= 10; n++) begin
      term = (term * x2 + Q30_HALF) >> 30;
      term = fcg_taylor_div(term, n);
      if ((n & 1) != 0) begin
        sum = sum - signed'(term);
      end else begin
        sum = sum + signed'(term);
      end
    end
    if (sum < 0) begin
      sum = '0;
    end
    val = (unsigned'(sum) * sine_fs + Q30_HALF) >> 30;
    if (val > sine_fs) begin
      val = sine_fs;
    end
    return val;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/fcg_front.sv
// ----------------------------------------------------------------------------
// fcg_front
// segment sequencer: classifies each request into segment, position and start
// ----------------------------------------------------------------------------
`default_nettype none

module fcg_front import fcg_pkg::*; #(
  parameter int LEN_BITS = FCG_LEN_BITS
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                req,
  input  wire logic [LEN_BITS-1:0] cw_len,
  input  wire logic [LEN_BITS-1:0] up_len,
  input  wire logic [LEN_BITS-1:0] down_len,
  output fcg_ctl_t                 item_ctl,
  output logic      [LEN_BITS-1:0] item_pos
);

  seg_t                seg_state;
  seg_t                seg_state_next;
  logic [LEN_BITS-1:0] seg_pos;
  logic [LEN_BITS-1:0] seg_pos_next;

  seg_t                seg;
  logic [LEN_BITS-1:0] pos;
  logic                cw_mode;
  logic                start;

  function automatic logic [LEN_BITS-1:0] len_of(input seg_t s, input logic [LEN_BITS-1:0] l0,
                                                 input logic [LEN_BITS-1:0] l1,
                                                 input logic [LEN_BITS-1:0] l2);
    logic [LEN_BITS-1:0] l;
    unique case (s)
      SEG_CW:   l = l0;
      SEG_UP:   l = l1;
      SEG_DOWN: l = l2;
      default:  l = l0;
    endcase
    return l;
  endfunction

  function automatic seg_t seg_after(input seg_t s);
    seg_t n;
    unique case (s)
      SEG_CW:   n = SEG_UP;
      SEG_UP:   n = SEG_DOWN;
      default:  n = SEG_CW;
    endcase
    return n;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_state <= SEG_CW;
      seg_pos   <= '0;
    end else begin
      seg_state <= seg_state_next;
      seg_pos   <= seg_pos_next;
    end
  end

  always_comb begin
    seg = (seg_state == SEG_DOWN || seg_state == SEG_UP) ? seg_state : SEG_CW;
    pos = seg_pos;
    // skip exhausted or empty segments, at most one full turn
    for (int n = 0; n < 3; n++) begin
      if (pos >= len_of(seg, cw_len, up_len, down_len)) begin
        seg = seg_after(seg);
        pos = '0;
      end
    end
    cw_mode = pos >= len_of(seg, cw_len, up_len, down_len);
    if (cw_mode) begin
      seg = SEG_CW;
      pos = '0;
    end
    start = !cw_mode && (pos == '0) &&
            (seg == SEG_CW || (seg == SEG_UP && cw_len == '0) ||
             (seg == SEG_DOWN && cw_len == '0 && up_len == '0));

    item_ctl.start = start;
    item_ctl.seg   = seg;
    item_pos       = pos;

    seg_state_next = seg_state;
    seg_pos_next   = seg_pos;
    if (req) begin
      seg_state_next = seg;
      seg_pos_next   = cw_mode ? '0 : pos + LEN_BITS'(1);
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/fcg_queue.sv
// ----------------------------------------------------------------------------
// fcg_queue
// short first-in first-out queue between the sequencer and the datapath
// ----------------------------------------------------------------------------
`default_nettype none

module fcg_queue import fcg_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] pop_data,
  output logic                  not_empty
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    slots [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;
  logic                do_push;
  logic                do_pop;

  function automatic logic [PTR_BITS-1:0] ptr_inc(input logic [PTR_BITS-1:0] p);
    return (p == PTR_BITS'(DEPTH - 1)) ? '0 : p + PTR_BITS'(1);
  endfunction

  assign full      = count == CNT_BITS'(DEPTH);
  assign not_empty = count != '0;
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_BITS'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/fcg_back.sv
// ----------------------------------------------------------------------------
// fcg_back
// sample datapath: frequency word, phase accumulator, sine table, gain
// ----------------------------------------------------------------------------
`default_nettype none

module fcg_back import fcg_pkg::*; #(
  parameter int PHASE_BITS    = FCG_PHASE_BITS,
  parameter int LUT_ADDR_BITS = FCG_LUT_ADDR_BITS,
  parameter int SAMPLE_BITS   = FCG_SAMPLE_BITS,
  parameter int LEN_BITS      = FCG_LEN_BITS
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire fcg_cfg_t                   cfg,
  input  wire logic                       item_valid,
  input  wire fcg_ctl_t                   item_ctl,
  input  wire logic        [LEN_BITS-1:0] item_pos,
  output logic                            item_pop,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic signed      [OUT_BITS-1:0] i_sample,
  output logic signed      [OUT_BITS-1:0] q_sample,
  output logic                            packet_start,
  output seg_t                            segment
);

  localparam int LUT_N  = 1 << LUT_ADDR_BITS;
  localparam int IDX_W  = LUT_ADDR_BITS + 1;
  localparam int P_W    = LUT_ADDR_BITS + 2;
  localparam int MAG_W  = SAMPLE_BITS - 1;
  localparam int PROD_W = SAMPLE_BITS + 17;
  localparam int MUL_W  = FREQ_BITS + LEN_BITS;

  localparam logic signed [PROD_W-1:0] ROUND  = PROD_W'(1) <<< (SAMPLE_BITS - 2);
  localparam logic signed [PROD_W-1:0] SAT_HI = PROD_W'((1 << (OUT_BITS - 1)) - 1);
  localparam logic signed [PROD_W-1:0] SAT_LO = -PROD_W'(1 << (OUT_BITS - 1));

  typedef logic [MAG_W-1:0] qtab_t [0:LUT_N];

  function automatic qtab_t build_qtab();
    qtab_t       t;
    logic [63:0] e;
    for (int k = 0; k <= LUT_N; k++) begin
      e    = fcg_sine_entry(k, LUT_ADDR_BITS, SAMPLE_BITS);
      t[k] = e[MAG_W-1:0];
    end
    return t;
  endfunction

  localparam qtab_t QTAB = build_qtab();

  function automatic logic signed [OUT_BITS-1:0] round_sat(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] v;
    logic signed [OUT_BITS-1:0] r;
    v = (p + ROUND) >>> (SAMPLE_BITS - 1);
    if (v > SAT_HI) begin
      r = SAT_HI[OUT_BITS-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[OUT_BITS-1:0];
    end else begin
      r = v[OUT_BITS-1:0];
    end
    return r;
  endfunction

  logic adv;

  // stage 1: step times position
  logic                 v1;
  fcg_ctl_t             c1;
  logic [FREQ_BITS-1:0] prod1;
  logic [MUL_W-1:0]     mul_full;

  // stage 2: frequency word
  logic                 v2;
  fcg_ctl_t             c2;
  logic [FREQ_BITS-1:0] freq2;
  logic [FREQ_BITS-1:0] freq_next;

  // stage 3: phase read and advance
  logic                  v3;
  fcg_ctl_t              c3;
  logic [P_W-1:0]        p3;
  logic [PHASE_BITS-1:0] phase_acc;
  logic [PHASE_BITS-1:0] phase_step;

  // stage 4: quarter-wave table read
  logic             v4;
  fcg_ctl_t         c4;
  logic [MAG_W-1:0] mag_s4;
  logic [MAG_W-1:0] mag_c4;
  logic             neg_s4;
  logic             neg_c4;
  logic [1:0]       quad_s;
  logic [1:0]       quad_c;
  logic [IDX_W-1:0] r_ext;
  logic [IDX_W-1:0] idx_s;
  logic [IDX_W-1:0] idx_c;

  // stage 5: gain
  logic                     v5;
  fcg_ctl_t                 c5;
  logic signed [PROD_W-1:0] prod_i5;
  logic signed [PROD_W-1:0] prod_q5;
  logic signed [16:0]           amp_s;
  logic signed [SAMPLE_BITS-1:0] cos_v;
  logic signed [SAMPLE_BITS-1:0] sin_v;

  assign adv      = !out_valid || out_ready;
  assign item_pop = adv && item_valid;

  assign mul_full = (item_ctl.seg == SEG_UP ? unsigned'(cfg.up_step) : unsigned'(cfg.down_step))
                    * MUL_W'(item_pos);

  always_comb begin
    unique case (c1.seg)
      SEG_UP:   freq_next = unsigned'(cfg.base_freq) + prod1;
      SEG_DOWN: freq_next = unsigned'(cfg.base_freq) + unsigned'(cfg.sweep_width) - prod1;
      default:  freq_next = unsigned'(cfg.base_freq);
    endcase
  end

  generate
    if (PHASE_BITS >= FREQ_BITS) begin : g_step_wide
      assign phase_step = PHASE_BITS'(freq2) << (PHASE_BITS - FREQ_BITS);
    end else begin : g_step_narrow
      assign phase_step = PHASE_BITS'(freq2 >> (FREQ_BITS - PHASE_BITS));
    end
  endgenerate

  // cosine sits one quarter ahead of sine
  assign quad_s = p3[P_W-1 -: 2];
  assign quad_c = quad_s + 2'd1;
  assign r_ext  = {1'b0, p3[LUT_ADDR_BITS-1:0]};
  assign idx_s  = quad_s[0] ? IDX_W'(LUT_N) - r_ext : r_ext;
  assign idx_c  = quad_c[0] ? IDX_W'(LUT_N) - r_ext : r_ext;

  assign amp_s = signed'({1'b0, cfg.amplitude});
  assign cos_v = neg_c4 ? -signed'({1'b0, mag_c4}) : signed'({1'b0, mag_c4});
  assign sin_v = neg_s4 ? -signed'({1'b0, mag_s4}) : signed'({1'b0, mag_s4});

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      v5        <= 1'b0;
      out_valid <= 1'b0;
      phase_acc <= '0;
    end else if (adv) begin
      v1        <= item_valid;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      v5        <= v4;
      out_valid <= v5;
      if (v2) begin
        phase_acc <= phase_acc + phase_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c1      <= item_ctl;
      prod1   <= mul_full[FREQ_BITS-1:0];
      c2      <= c1;
      freq2   <= freq_next;
      c3      <= c2;
      p3      <= phase_acc[PHASE_BITS-1 -: P_W];
      c4      <= c3;
      mag_s4  <= QTAB[idx_s];
      mag_c4  <= QTAB[idx_c];
      neg_s4  <= quad_s[1];
      neg_c4  <= quad_c[1];
      c5      <= c4;
      prod_i5 <= amp_s * cos_v;
      prod_q5 <= amp_s * sin_v;
      i_sample     <= round_sat(prod_i5);
      q_sample     <= round_sat(prod_q5);
      packet_start <= c5.start;
      segment      <= c5.seg;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/fmcw_chirp_generator.sv
// ----------------------------------------------------------------------------
// fmcw_chirp_generator
// triangular fmcw chirp oscillator producing complex baseband samples
// ----------------------------------------------------------------------------
// Every request on the input stream with bit 0 of s_tdata set yields one
// complex sample on the output stream; a request with that bit clear is
// taken and dropped. A packet is cw_len samples at base_freq, up_len samples
// rising by up_step per sample, then down_len samples falling from
// base_freq + sweep_width by down_step per sample, repeated for ever; empty
// segments are skipped and all lengths zero gives plain cw. The phase
// accumulator is never cleared between packets. Sustained rate is one
// sample per clock while m_tready is high: the phase accumulator is one
// add in a single stage and everything else is pipelined. A request
// passes the queue, the pipeline stage registers and the output
// register before its sample appears. A short request queue sits between
// the segment sequencer and the datapath, so up to four more requests are
// taken while a finished sample waits on m_tready. Registers are written
// over the apb port and should only change while no sample is in flight.
`default_nettype none

module fmcw_chirp_generator import fcg_pkg::*; #(
  parameter int PHASE_BITS    = FCG_PHASE_BITS,
  parameter int LUT_ADDR_BITS = FCG_LUT_ADDR_BITS,
  parameter int SAMPLE_BITS   = FCG_SAMPLE_BITS,
  parameter int LEN_BITS      = FCG_LEN_BITS
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  // request stream
  input  wire logic                     s_tvalid,
  output logic                          s_tready,
  input  wire logic [7:0]               s_tdata,   // [0] tick, [7:1] zero
  // sample stream
  output logic                          m_tvalid,
  input  wire logic                     m_tready,
  output logic      [31:0]              m_tdata,   // [15:0] i_sample, [31:16] q_sample
  output logic      [2:0]               m_tuser,   // [0] packet_start, [2:1] segment
  // register port
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [APB_ADDR_BITS-1:0] paddr,
  input  wire logic [APB_DATA_BITS-1:0] pwdata,
  output logic      [APB_DATA_BITS-1:0] prdata,
  output logic                          pready
);

  localparam int ITEM_W = $bits(fcg_ctl_t) + LEN_BITS;

  fcg_cfg_t cfg;
  reg_idx_t reg_sel;
  logic     cfg_wr;

  // front side signals
  logic                front_req;
  fcg_ctl_t            front_ctl;
  logic [LEN_BITS-1:0] front_pos;
  logic                q_full;

  // back side signals
  logic                q_not_empty;
  logic                q_pop;
  logic [ITEM_W-1:0]   q_data;
  fcg_ctl_t            back_ctl;
  logic [LEN_BITS-1:0] back_pos;

  logic signed [OUT_BITS-1:0] i_sample;
  logic signed [OUT_BITS-1:0] q_sample;
  logic                       packet_start;
  seg_t                       segment;

  // register port: always ready, written in the access phase
  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[APB_ADDR_BITS-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cw_len      <= '0;
      cfg.up_len      <= '0;
      cfg.down_len    <= '0;
      cfg.base_freq   <= '0;
      cfg.sweep_width <= '0;
      cfg.up_step     <= '0;
      cfg.down_step   <= '0;
      cfg.amplitude   <= AMP_RESET;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_CW_LEN:      cfg.cw_len      <= pwdata[CFG_LEN_BITS-1:0];
        REG_UP_LEN:      cfg.up_len      <= pwdata[CFG_LEN_BITS-1:0];
        REG_DOWN_LEN:    cfg.down_len    <= pwdata[CFG_LEN_BITS-1:0];
        REG_BASE_FREQ:   cfg.base_freq   <= signed'(pwdata[FREQ_BITS-1:0]);
        REG_SWEEP_WIDTH: cfg.sweep_width <= signed'(pwdata[FREQ_BITS-1:0]);
        REG_UP_STEP:     cfg.up_step     <= signed'(pwdata[FREQ_BITS-1:0]);
        REG_DOWN_STEP:   cfg.down_step   <= signed'(pwdata[FREQ_BITS-1:0]);
        REG_AMPLITUDE:   cfg.amplitude   <= pwdata[15:0];
      endcase
    end
  end

  // read back, 16-bit registers zero-extended
  always_comb begin
    unique case (reg_sel)
      REG_CW_LEN:      prdata = APB_DATA_BITS'(cfg.cw_len);
      REG_UP_LEN:      prdata = APB_DATA_BITS'(cfg.up_len);
      REG_DOWN_LEN:    prdata = APB_DATA_BITS'(cfg.down_len);
      REG_BASE_FREQ:   prdata = unsigned'(cfg.base_freq);
      REG_SWEEP_WIDTH: prdata = unsigned'(cfg.sweep_width);
      REG_UP_STEP:     prdata = unsigned'(cfg.up_step);
      REG_DOWN_STEP:   prdata = unsigned'(cfg.down_step);
      REG_AMPLITUDE:   prdata = APB_DATA_BITS'(cfg.amplitude);
    endcase
  end

  // requests are taken whenever the queue has room
  assign s_tready  = !q_full;
  assign front_req = s_tvalid && s_tready && s_tdata[0];

  fcg_front #(
    .LEN_BITS (LEN_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .req      (front_req),
    .cw_len   (LEN_BITS'(cfg.cw_len)),
    .up_len   (LEN_BITS'(cfg.up_len)),
    .down_len (LEN_BITS'(cfg.down_len)),
    .item_ctl (front_ctl),
    .item_pos (front_pos)
  );

  // queue entry: control in the top bits, position below
  fcg_queue #(
    .WIDTH (ITEM_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (front_req),
    .push_data ({front_ctl, front_pos}),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_data),
    .not_empty (q_not_empty)
  );

  assign back_ctl = fcg_ctl_t'(q_data[ITEM_W-1:LEN_BITS]);
  assign back_pos = q_data[LEN_BITS-1:0];

  fcg_back #(
    .PHASE_BITS    (PHASE_BITS),
    .LUT_ADDR_BITS (LUT_ADDR_BITS),
    .SAMPLE_BITS   (SAMPLE_BITS),
    .LEN_BITS      (LEN_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .item_valid   (q_not_empty),
    .item_ctl     (back_ctl),
    .item_pos     (back_pos),
    .item_pop     (q_pop),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .i_sample     (i_sample),
    .q_sample     (q_sample),
    .packet_start (packet_start),
    .segment      (segment)
  );

  assign m_tdata = {q_sample, i_sample};
  assign m_tuser = {segment, packet_start};

endmodule

`default_nettype wire

FILE: hw/rtl/fcg_checker.sv
// ----------------------------------------------------------------------------
// fcg_checker
// port-level checks of the chirp generator, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "fmcw_chirp_generator_defines.svh"

module fcg_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [31:0] m_tdata,
  input wire logic [2:0]  m_tuser
);

  // a stalled sample keeps its value
  `FCG_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "sample changed while stalled")

  // with the output register empty the request queue cannot be full
  `FCG_ASSERT_NOW(a_ready_when_drained, !m_tvalid, s_tready, "requests refused with output empty")

  // reset leaves no sample pending
  `FCG_ASSERT_NOW(a_empty_after_reset, $past(rst), !m_tvalid, "sample pending after reset")

endmodule

bind fmcw_chirp_generator fcg_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire
